[rtl/core/awn_pkg.sv]
package awn_pkg;

  // Field widths
  localparam int ROW_W     = 11;
  localparam int COL_W     = 11;
  localparam int PIX_W     = 24;
  localparam int STAT_W    = 2;
  localparam int COEF_W    = 16;
  localparam int SIZE_W    = 9;
  localparam int CFG_IDX_W = 3;

  // Internal arithmetic widths
  localparam int DIM_W  = 12;  // effective source size, up to 511
  localparam int OSZ_W  = 17;  // signed output frame size
  localparam int PROD_W = 28;  // coefficient times coordinate
  localparam int NUM_W  = 29;  // difference of two products
  localparam int DET_W  = 33;  // determinant
  localparam int DMAG_W = 36;  // 16 * |det|
  localparam int SDET_W = 49;  // shift times det
  localparam int TOP_W  = 50;  // dividend

  localparam int DEF_MAX_WIDTH  = 256;
  localparam int DEF_MAX_HEIGHT = 256;
  localparam int QUEUE_DEPTH    = 4;
  localparam int SETTLE_CYCLES  = 6;

  localparam logic [CFG_IDX_W-1:0] REG_COEF_A     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_B     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_C     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_D     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SHIFT_X    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SHIFT_Y    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT = 3'd7;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_READ  = 1'b1;

  localparam logic [STAT_W-1:0] ST_COPIED        = 2'd0;
  localparam logic [STAT_W-1:0] ST_OUTSIDE_SRC   = 2'd1;
  localparam logic [STAT_W-1:0] ST_OUTSIDE_FRAME = 2'd2;
  localparam logic [STAT_W-1:0] ST_SINGULAR      = 2'd3;

  typedef enum logic [1:0] {
    KIND_WRITE,
    KIND_SKIP,
    KIND_MAP,
    KIND_FIXED
  } kind_t;

  typedef struct packed {
    logic             opcode;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic [PIX_W-1:0] pixel_in;
  } in_word_t;

  typedef struct packed {
    logic [PIX_W-1:0]  pixel_out;
    logic [STAT_W-1:0] status;
  } out_word_t;

  typedef struct packed {
    kind_t             kind;
    logic [STAT_W-1:0] status;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
    logic [PIX_W-1:0]  pixel;
  } q_entry_t;

  typedef struct packed {
    logic signed [COEF_W-1:0] a;
    logic signed [COEF_W-1:0] b;
    logic signed [COEF_W-1:0] c;
    logic signed [COEF_W-1:0] d;
    logic [DIM_W-1:0]         eff_w;
    logic [DIM_W-1:0]         eff_h;
    logic signed [OSZ_W-1:0]  out_w;
    logic signed [OSZ_W-1:0]  out_h;
    logic                     det_zero;
    logic                     det_neg;
    logic [DMAG_W-1:0]        dmag;
    logic signed [SDET_W-1:0] sxdet;
    logic signed [SDET_W-1:0] sydet;
  } cfg_view_t;

endpackage

[rtl/core/affine_warp_nearest.sv]
// Affine warp over a frame store with nearest-neighbor lookup.
// Input channel (in_valid / in_stall / in_data): a word with opcode write
// stores pixel_in at (row, col) of the source; a word with opcode read names
// an output pixel, which is mapped back through the inverse matrix and
// answered with the source pixel or black plus a status code.
// Result channel (out_valid / out_stall / out_data): one word per read, in
// input order; writes give no result.
// Configuration channel (cfg_valid / cfg_ready / cfg_index / cfg_data):
// write only while the block is idle. After each write, and after reset,
// in_stall stays high while the determinant and the products
// that depend on it settle.
// Throughput: one word per cycle while in_stall is low. After the queue a
// word passes products, dividends, K = clog2(max(MAX_WIDTH, MAX_HEIGHT))
// divider steps of one quotient bit each, bounds and address, memory read.
// A 4-entry queue sits between the classifier and the datapath. When the
// receiver stalls, the datapath and result hold; the queue keeps taking
// words until full, then in_stall rises.
// Reset clears the control state; frame store contents are kept.
module affine_warp_nearest #(
  parameter int MAX_WIDTH  = awn_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = awn_pkg::DEF_MAX_HEIGHT
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  awn_pkg::in_word_t             in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output awn_pkg::out_word_t            out_data,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [awn_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [awn_pkg::COEF_W-1:0]    cfg_data
);

  awn_pkg::cfg_view_t view;
  awn_pkg::q_entry_t  entry_in, entry_out;
  logic               busy, q_full, q_valid, q_pop, push;

  assign in_stall = q_full || busy;
  assign push     = in_valid && !in_stall;

  awn_cfg #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .view      (view),
    .busy      (busy)
  );

  awn_front u_front (
    .in_word (in_data),
    .view    (view),
    .entry   (entry_in)
  );

  awn_queue #(
    .DEPTH (awn_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .din       (entry_in),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .dout      (entry_out)
  );

  awn_back #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .view      (view),
    .q_valid   (q_valid),
    .q_entry   (entry_out),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

[rtl/core/awn_ram.sv]
module awn_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [0:DEPTH-1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/core/awn_cfg.sv]
module awn_cfg #(
  parameter int MAX_WIDTH  = awn_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = awn_pkg::DEF_MAX_HEIGHT
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [awn_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [awn_pkg::COEF_W-1:0]      cfg_data,
  output awn_pkg::cfg_view_t              view,
  output logic                            busy
);

  localparam int DW  = awn_pkg::DIM_W;
  localparam int OW  = awn_pkg::OSZ_W;
  localparam int CFW = awn_pkg::COEF_W;
  localparam int SZW = awn_pkg::SIZE_W;
  localparam int DTW = awn_pkg::DET_W;
  localparam int DMW = awn_pkg::DMAG_W;
  localparam int SDW = awn_pkg::SDET_W;
  localparam int LOW = 17;
  localparam logic [DW-1:0] MW = DW'(MAX_WIDTH);
  localparam logic [DW-1:0] MH = DW'(MAX_HEIGHT);
  localparam logic [2:0] SETTLE = 3'(awn_pkg::SETTLE_CYCLES);

  logic signed [CFW-1:0] coef_a_r, coef_b_r, coef_c_r, coef_d_r;
  logic signed [CFW-1:0] shift_x_r, shift_y_r;
  logic [SZW-1:0]        src_width_r, src_height_r;
  logic [2:0]            settle_r;

  logic [DW-1:0]         eff_w, eff_h;
  logic [DW-1:0]         eff_w_r, eff_h_r;
  logic signed [28:0]    prod_w, prod_h;
  logic signed [OW-1:0]  out_w_r, out_h_r;
  logic signed [31:0]    ad_r, bc_r;
  logic signed [DTW-1:0] det_r;
  logic [DTW-1:0]        det_abs;
  logic                  det_zero_r, det_neg_r;
  logic [DMW-1:0]        dmag_r;
  logic signed [33:0]    px_lo_r, py_lo_r;
  logic signed [31:0]    px_hi_r, py_hi_r;
  logic signed [SDW-1:0] sxdet_r, sydet_r;

  function automatic logic signed [OW-1:0] trunc_q12(input logic signed [28:0] p);
    logic [28:0] mag;
    logic [28:0] q;
    mag = p[28] ? 29'(-p) : 29'(p);
    q   = mag >> 12;
    trunc_q12 = p[28] ? OW'(-$signed(q)) : OW'($signed(q));
  endfunction

  assign cfg_ready = 1'b1;
  assign busy      = (settle_r != 3'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_a_r     <= 16'sd4096;
      coef_b_r     <= '0;
      coef_c_r     <= '0;
      coef_d_r     <= 16'sd4096;
      shift_x_r    <= '0;
      shift_y_r    <= '0;
      src_width_r  <= 9'd256;
      src_height_r <= 9'd256;
      settle_r     <= SETTLE;
    end else if (cfg_valid && cfg_ready) begin
      settle_r <= SETTLE;
      case (cfg_index)
        awn_pkg::REG_COEF_A:     coef_a_r     <= cfg_data;
        awn_pkg::REG_COEF_B:     coef_b_r     <= cfg_data;
        awn_pkg::REG_COEF_C:     coef_c_r     <= cfg_data;
        awn_pkg::REG_COEF_D:     coef_d_r     <= cfg_data;
        awn_pkg::REG_SHIFT_X:    shift_x_r    <= cfg_data;
        awn_pkg::REG_SHIFT_Y:    shift_y_r    <= cfg_data;
        awn_pkg::REG_SRC_WIDTH:  src_width_r  <= cfg_data[SZW-1:0];
        awn_pkg::REG_SRC_HEIGHT: src_height_r <= cfg_data[SZW-1:0];
        default: ;
      endcase
    end else if (settle_r != 3'd0) begin
      settle_r <= settle_r - 3'd1;
    end
  end

  assign eff_w   = (DW'(src_width_r) > MW) ? MW : DW'(src_width_r);
  assign eff_h   = (DW'(src_height_r) > MH) ? MH : DW'(src_height_r);
  assign prod_w  = $signed({1'b0, eff_w}) * coef_a_r;
  assign prod_h  = $signed({1'b0, eff_h}) * coef_d_r;
  assign det_abs = det_r[DTW-1] ? DTW'(-det_r) : DTW'(det_r);

  // derived values are registered and settle in turn; input is held off meanwhile
  always_ff @(posedge clk) begin
    eff_w_r    <= eff_w;
    eff_h_r    <= eff_h;
    out_w_r    <= trunc_q12(prod_w);
    out_h_r    <= trunc_q12(prod_h);
    ad_r       <= coef_a_r * coef_d_r;
    bc_r       <= coef_b_r * coef_c_r;
    det_r      <= DTW'(ad_r) - DTW'(bc_r);
    det_zero_r <= (det_r == '0);
    det_neg_r  <= det_r[DTW-1];
    dmag_r     <= {det_abs[31:0], 4'b0000};
    px_lo_r    <= shift_x_r * $signed({1'b0, det_r[LOW-1:0]});
    py_lo_r    <= shift_y_r * $signed({1'b0, det_r[LOW-1:0]});
    px_hi_r    <= shift_x_r * $signed(det_r[DTW-1:LOW]);
    py_hi_r    <= shift_y_r * $signed(det_r[DTW-1:LOW]);
    sxdet_r    <= (SDW'(px_hi_r) <<< LOW) + SDW'(px_lo_r);
    sydet_r    <= (SDW'(py_hi_r) <<< LOW) + SDW'(py_lo_r);
  end

  always_comb begin
    view.a        = coef_a_r;
    view.b        = coef_b_r;
    view.c        = coef_c_r;
    view.d        = coef_d_r;
    view.eff_w    = eff_w_r;
    view.eff_h    = eff_h_r;
    view.out_w    = out_w_r;
    view.out_h    = out_h_r;
    view.det_zero = det_zero_r;
    view.det_neg  = det_neg_r;
    view.dmag     = dmag_r;
    view.sxdet    = sxdet_r;
    view.sydet    = sydet_r;
  end

endmodule

[rtl/core/awn_front.sv]
module awn_front (
  input  awn_pkg::in_word_t  in_word,
  input  awn_pkg::cfg_view_t view,
  output awn_pkg::q_entry_t  entry
);

  localparam int DW = awn_pkg::DIM_W;
  localparam int OW = awn_pkg::OSZ_W;

  logic in_src, in_frame;

  assign in_src   = (DW'(in_word.row) < view.eff_h) && (DW'(in_word.col) < view.eff_w);
  assign in_frame = ($signed(OW'(in_word.row)) < view.out_h) &&
                    ($signed(OW'(in_word.col)) < view.out_w);

  always_comb begin
    entry.row    = in_word.row;
    entry.col    = in_word.col;
    entry.pixel  = in_word.pixel_in;
    entry.status = awn_pkg::ST_COPIED;
    if (in_word.opcode == awn_pkg::OP_WRITE) begin
      entry.kind = in_src ? awn_pkg::KIND_WRITE : awn_pkg::KIND_SKIP;
    end else if (!in_frame) begin
      entry.kind   = awn_pkg::KIND_FIXED;
      entry.status = awn_pkg::ST_OUTSIDE_FRAME;
    end else if (view.det_zero) begin
      entry.kind   = awn_pkg::KIND_FIXED;
      entry.status = awn_pkg::ST_SINGULAR;
    end else begin
      entry.kind = awn_pkg::KIND_MAP;
    end
  end

endmodule

[rtl/core/awn_queue.sv]
module awn_queue #(
  parameter int DEPTH = awn_pkg::QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  awn_pkg::q_entry_t  din,
  output logic               full,
  input  logic               pop,
  output logic               not_empty,
  output awn_pkg::q_entry_t  dout
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
  localparam logic [PW:0]   FULL_CNT = (PW + 1)'(DEPTH);

  awn_pkg::q_entry_t slot_r [0:DEPTH-1];
  logic [PW-1:0] wr_r, rd_r;
  logic [PW:0]   cnt_r;

  assign full      = (cnt_r == FULL_CNT);
  assign not_empty = (cnt_r != '0);
  assign dout      = slot_r[rd_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wr_r <= (wr_r == LAST) ? '0 : wr_r + PW'(1);
      end
      if (pop) begin
        rd_r <= (rd_r == LAST) ? '0 : rd_r + PW'(1);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + (PW + 1)'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - (PW + 1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_r] <= din;
    end
  end

endmodule

[rtl/core/awn_back.sv]
module awn_back #(
  parameter int MAX_WIDTH  = awn_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = awn_pkg::DEF_MAX_HEIGHT
) (
  input  logic               clk,
  input  logic               rst_n,
  input  awn_pkg::cfg_view_t view,
  input  logic               q_valid,
  input  awn_pkg::q_entry_t  q_entry,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_stall,
  output awn_pkg::out_word_t out_data
);

  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int RW  = $clog2(MAX_HEIGHT);
  localparam int K   = $clog2((MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT);
  localparam int AW  = $clog2(MAX_WIDTH * MAX_HEIGHT);
  localparam int TW  = awn_pkg::TOP_W;
  localparam int PRW = awn_pkg::PROD_W;
  localparam int NW  = awn_pkg::NUM_W;
  localparam int DW  = awn_pkg::DIM_W;
  localparam int PXW = awn_pkg::PIX_W;
  localparam int SW  = awn_pkg::STAT_W;

  logic en;

  // stage 1: products
  logic                  s1_v_r;
  awn_pkg::q_entry_t     s1_e_r;
  logic signed [PRW-1:0] pdc_r, pbr_r, par_r, pcc_r;

  // stage 2: dividends
  logic                  s2_v_r;
  awn_pkg::q_entry_t     s2_e_r;
  logic signed [TW-1:0]  topx_r, topy_r;
  logic signed [NW-1:0]  numx, numy;

  // stage 3 and divider steps, index 0 is stage 3
  logic                  dv_r   [0:K];
  awn_pkg::q_entry_t     de_r   [0:K];
  logic [TW-1:0]         remx_r [0:K];
  logic [TW-1:0]         remy_r [0:K];
  logic [K-1:0]          qx_r   [0:K];
  logic [K-1:0]          qy_r   [0:K];
  logic                  negx_r [0:K];
  logic                  negy_r [0:K];
  logic                  ovfx_r [0:K];
  logic                  ovfy_r [0:K];
  logic [TW-1:0]         magx, magy, dlim;

  // stage 4: bounds and address
  logic                  s4_v_r;
  awn_pkg::kind_t        s4_kind_r;
  logic [SW-1:0]         s4_status_r;
  logic [AW-1:0]         s4_addr_r;
  logic [PXW-1:0]        s4_pix_r;
  logic [K-1:0]          sx_val, sy_val;
  logic                  failx, faily;
  logic [RW-1:0]         row_sel;
  logic [CW-1:0]         col_sel;
  logic [SW-1:0]         status4;
  awn_pkg::q_entry_t     e4;

  // stage 5: memory read
  logic                  s5_v_r;
  logic                  s5_read_r;
  logic [SW-1:0]         s5_status_r;
  logic [PXW-1:0]        rdata;

  assign out_valid = s5_v_r && s5_read_r;
  assign en        = !(out_valid && out_stall);
  assign q_pop     = en && q_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      dv_r[0] <= 1'b0;
      s4_v_r <= 1'b0;
      s5_v_r <= 1'b0;
    end else if (en) begin
      s1_v_r  <= q_valid;
      s2_v_r  <= s1_v_r;
      dv_r[0] <= s2_v_r;
      s4_v_r  <= dv_r[K];
      s5_v_r  <= s4_v_r;
    end
  end

  assign numx = NW'(pdc_r) - NW'(pbr_r);
  assign numy = NW'(par_r) - NW'(pcc_r);
  assign magx = topx_r[TW-1] ? TW'(-topx_r) : TW'(topx_r);
  assign magy = topy_r[TW-1] ? TW'(-topy_r) : TW'(topy_r);
  assign dlim = TW'(view.dmag) << K;

  always_ff @(posedge clk) begin
    if (en) begin
      s1_e_r <= q_entry;
      pdc_r  <= view.d * $signed({1'b0, q_entry.col});
      pbr_r  <= view.b * $signed({1'b0, q_entry.row});
      par_r  <= view.a * $signed({1'b0, q_entry.row});
      pcc_r  <= view.c * $signed({1'b0, q_entry.col});

      s2_e_r <= s1_e_r;
      topx_r <= (TW'(numx) <<< 16) - TW'(view.sxdet);
      topy_r <= (TW'(numy) <<< 16) - TW'(view.sydet);

      de_r[0]   <= s2_e_r;
      remx_r[0] <= magx;
      remy_r[0] <= magy;
      qx_r[0]   <= '0;
      qy_r[0]   <= '0;
      negx_r[0] <= topx_r[TW-1] ^ view.det_neg;
      negy_r[0] <= topy_r[TW-1] ^ view.det_neg;
      ovfx_r[0] <= (magx >= dlim);
      ovfy_r[0] <= (magy >= dlim);
    end
  end

  // one quotient bit per step, most significant first
  for (genvar i = 0; i < K; i++) begin : g_div
    localparam int SH = K - 1 - i;
    logic [TW-1:0] dsh;
    logic          gex, gey;

    assign dsh = TW'(view.dmag) << SH;
    assign gex = (remx_r[i] >= dsh);
    assign gey = (remy_r[i] >= dsh);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_r[i+1] <= 1'b0;
      end else if (en) begin
        dv_r[i+1] <= dv_r[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        de_r[i+1]   <= de_r[i];
        remx_r[i+1] <= gex ? remx_r[i] - dsh : remx_r[i];
        remy_r[i+1] <= gey ? remy_r[i] - dsh : remy_r[i];
        qx_r[i+1]   <= K'({qx_r[i], gex});
        qy_r[i+1]   <= K'({qy_r[i], gey});
        negx_r[i+1] <= negx_r[i];
        negy_r[i+1] <= negy_r[i];
        ovfx_r[i+1] <= ovfx_r[i];
        ovfy_r[i+1] <= ovfy_r[i];
      end
    end
  end

  assign e4     = de_r[K];
  assign sx_val = negx_r[K] ? '0 : qx_r[K];
  assign sy_val = negy_r[K] ? '0 : qy_r[K];
  assign failx  = ovfx_r[K] || (negx_r[K] && (qx_r[K] != '0)) ||
                  (DW'(sx_val) >= view.eff_w);
  assign faily  = ovfy_r[K] || (negy_r[K] && (qy_r[K] != '0)) ||
                  (DW'(sy_val) >= view.eff_h);

  always_comb begin
    row_sel = e4.row[RW-1:0];
    col_sel = e4.col[CW-1:0];
    status4 = e4.status;
    case (e4.kind)
      awn_pkg::KIND_MAP: begin
        row_sel = sy_val[RW-1:0];
        col_sel = sx_val[CW-1:0];
        status4 = (failx || faily) ? awn_pkg::ST_OUTSIDE_SRC : awn_pkg::ST_COPIED;
      end
      awn_pkg::KIND_WRITE: ;
      awn_pkg::KIND_FIXED: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_kind_r   <= e4.kind;
      s4_status_r <= status4;
      s4_addr_r   <= AW'(row_sel * MAX_WIDTH) + AW'(col_sel);
      s4_pix_r    <= e4.pixel;
      s5_read_r   <= (s4_kind_r == awn_pkg::KIND_MAP) || (s4_kind_r == awn_pkg::KIND_FIXED);
      s5_status_r <= s4_status_r;
    end
  end

  // writes and reads meet the store at the same stage, so order is kept
  awn_ram #(
    .WIDTH (PXW),
    .DEPTH (MAX_WIDTH * MAX_HEIGHT)
  ) u_store (
    .clk   (clk),
    .we    (en && s4_v_r && (s4_kind_r == awn_pkg::KIND_WRITE)),
    .waddr (s4_addr_r),
    .wdata (s4_pix_r),
    .re    (en),
    .raddr (s4_addr_r),
    .rdata (rdata)
  );

  assign out_data.pixel_out = (s5_status_r == awn_pkg::ST_COPIED) ? rdata : '0;
  assign out_data.status    = s5_status_r;

endmodule

[rtl/core/awn_checker.sv]
module awn_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input awn_pkg::out_word_t out_data,
  input logic               cfg_valid,
  input logic               cfg_ready
);

  // no result right after reset
  a_quiet_after_reset: assert property (@(posedge clk)
    $rose(rst_n) |-> !out_valid)
    else $error("result shown right after reset");

  a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result word changed");

  // input is held off while derived config settles
  a_settle: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid && cfg_ready |=> in_stall)
    else $error("input taken before config settled");

  a_black: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status != awn_pkg::ST_COPIED) |-> out_data.pixel_out == '0)
    else $error("non-copied result carries a pixel");

endmodule

bind affine_warp_nearest awn_checker u_awn_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data),
  .cfg_valid (cfg_valid),
  .cfg_ready (cfg_ready)
);

[dv/affine_warp_nearest_test.sv]
`timescale 1ns / 100ps

module affine_warp_nearest_test;

  localparam int STORE_W   = 256;
  localparam int STORE_H   = 256;
  localparam int DRAIN_CYC = 30;
  localparam int N_PHASE   = 38;
  localparam longint CYCLE_LIMIT = 3000000;

  typedef struct {
    awn_pkg::in_word_t  word;
    bit                 fixed;
    awn_pkg::out_word_t want;
  } dir_row_t;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  awn_pkg::in_word_t  in_data;
  logic               out_valid;
  logic               out_stall;
  awn_pkg::out_word_t out_data;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [awn_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [awn_pkg::COEF_W-1:0]    cfg_data;

  // predictor state
  logic signed [awn_pkg::COEF_W-1:0] m_a, m_b, m_c, m_d, m_sx, m_sy;
  logic [awn_pkg::SIZE_W-1:0]        m_w, m_h;
  logic [awn_pkg::PIX_W-1:0]         frame_mem [STORE_W*STORE_H];
  bit                                frame_written [STORE_W*STORE_H];

  awn_pkg::out_word_t pending_pixels [$];
  int        fail_count;
  bit        quiet;
  longint    cycle_count;

  affine_warp_nearest u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("** affine_warp_nearest: FAILED **");
      $finish;
    end
  end

  function automatic int gap_len();
    int p;
    p = $urandom_range(99);
    if (quiet || p < 60) return 0;
    if (p < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  // Inverse-map an output coordinate; returns the status and the source address.
  function automatic logic [awn_pkg::STAT_W-1:0] map_back(input int r, input int c,
                                                          output int addr);
    longint a, b, c_e, d, w, h, ow, oh, det, sx, sy;
    a = m_a; b = m_b; c_e = m_c; d = m_d;
    w = (m_w > STORE_W) ? STORE_W : m_w;
    h = (m_h > STORE_H) ? STORE_H : m_h;
    ow = (w * a) / 4096;
    oh = (h * d) / 4096;
    addr = 0;
    if (r >= oh || c >= ow) return awn_pkg::ST_OUTSIDE_FRAME;
    det = a * d - b * c_e;
    if (det == 0) return awn_pkg::ST_SINGULAR;
    sx = ((d * c - b * r) * 65536 - longint'(m_sx) * det) / (det * 16);
    if (sx < 0 || sx >= w) return awn_pkg::ST_OUTSIDE_SRC;
    sy = ((a * r - c_e * c) * 65536 - longint'(m_sy) * det) / (det * 16);
    if (sy < 0 || sy >= h) return awn_pkg::ST_OUTSIDE_SRC;
    addr = int'(sy) * STORE_W + int'(sx);
    return awn_pkg::ST_COPIED;
  endfunction

  // Apply one accepted word to the predictor; queue the result for reads.
  function automatic void predict_word(input awn_pkg::in_word_t w);
    int addr;
    int wd, ht;
    awn_pkg::out_word_t res;
    wd = (m_w > STORE_W) ? STORE_W : m_w;
    ht = (m_h > STORE_H) ? STORE_H : m_h;
    if (w.opcode == awn_pkg::OP_WRITE) begin
      if (w.row < ht && w.col < wd) begin
        frame_mem[w.row * STORE_W + w.col] = w.pixel_in;
        frame_written[w.row * STORE_W + w.col] = 1'b1;
      end
      return;
    end
    res.status = map_back(w.row, w.col, addr);
    res.pixel_out = (res.status == awn_pkg::ST_COPIED) ? frame_mem[addr] : '0;
    pending_pixels.push_back(res);
  endfunction

  task automatic send_word(input awn_pkg::in_word_t w, input bit fixed,
                           input awn_pkg::out_word_t want);
    @(negedge clk);
    in_valid = 1'b1;
    in_data  = w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (fixed) pending_pixels.push_back(want);
    else predict_word(w);
    repeat (gap_len()) begin
      @(negedge clk);
      in_valid = 1'b0;
      in_data  = awn_pkg::in_word_t'({$urandom, $urandom});
    end
  endtask

  task automatic write_reg(input logic [awn_pkg::CFG_IDX_W-1:0] idx,
                           input logic [awn_pkg::COEF_W-1:0] val);
    @(negedge clk);
    in_valid  = 1'b0;
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      awn_pkg::REG_COEF_A:     m_a = val;
      awn_pkg::REG_COEF_B:     m_b = val;
      awn_pkg::REG_COEF_C:     m_c = val;
      awn_pkg::REG_COEF_D:     m_d = val;
      awn_pkg::REG_SHIFT_X:    m_sx = val;
      awn_pkg::REG_SHIFT_Y:    m_sy = val;
      awn_pkg::REG_SRC_WIDTH:  m_w = val[awn_pkg::SIZE_W-1:0];
      awn_pkg::REG_SRC_HEIGHT: m_h = val[awn_pkg::SIZE_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // drop the input, then let everything in flight drain
  task automatic wait_idle();
    @(negedge clk);
    in_valid = 1'b0;
    @(posedge clk);
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
  endtask

  task automatic run_phase(input logic [awn_pkg::COEF_W-1:0] regs [8], input int n_items);
    awn_pkg::in_word_t w;
    int addr;
    int lim;
    awn_pkg::out_word_t none;
    none = '0;
    wait_idle();
    for (int i = 0; i < 8; i++) write_reg(awn_pkg::CFG_IDX_W'(i), regs[i]);
    quiet = ($urandom_range(3) == 0);
    lim = (m_w > STORE_W ? STORE_W : m_w) + 8;
    for (int i = 0; i < n_items; i++) begin
      w = awn_pkg::in_word_t'({$urandom, $urandom});
      if ($urandom_range(9) != 0) begin
        w.row = awn_pkg::ROW_W'($urandom_range(lim * 2));
        w.col = awn_pkg::COL_W'($urandom_range(lim * 2));
      end
      w.opcode = ($urandom_range(9) < 6) ? awn_pkg::OP_READ : awn_pkg::OP_WRITE;
      // never read an entry that was never written: fill it first
      if (w.opcode == awn_pkg::OP_READ && map_back(w.row, w.col, addr) == awn_pkg::ST_COPIED
          && !frame_written[addr])
        send_word(awn_pkg::in_word_t'{awn_pkg::OP_WRITE,
                                      awn_pkg::ROW_W'(addr / STORE_W),
                                      awn_pkg::COL_W'(addr % STORE_W),
                                      awn_pkg::PIX_W'($urandom)}, 1'b0, none);
      send_word(w, 1'b0, none);
    end
  endtask

  // result side: random stall, compare at the rising edge
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      out_stall = 1'b0;
      if (!quiet && $urandom_range(3) == 0) begin
        out_stall = 1'b1;
        repeat (gap_len()) @(negedge clk);
      end
    end
  end

  always @(posedge clk) begin
    awn_pkg::out_word_t exp_w;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_pixels.size() == 0) begin
        $error("unexpected result word: pixel_out %h status %0d",
               out_data.pixel_out, out_data.status);
        fail_count++;
      end else begin
        exp_w = pending_pixels.pop_front();
        if (out_data.pixel_out !== exp_w.pixel_out) begin
          $error("pixel_out: expected %h, got %h", exp_w.pixel_out, out_data.pixel_out);
          fail_count++;
        end
        if (out_data.status !== exp_w.status) begin
          $error("status: expected %0d, got %0d", exp_w.status, out_data.status);
          fail_count++;
        end
      end
    end
  end

  dir_row_t dir_rows [] = '{
    '{'{awn_pkg::OP_WRITE, 11'd0,    11'd0,    24'hFFFFFF}, 1'b0, '0},
    '{'{awn_pkg::OP_WRITE, 11'd255,  11'd255,  24'h000000}, 1'b0, '0},
    '{'{awn_pkg::OP_WRITE, 11'd0,    11'd255,  24'hAAAAAA}, 1'b0, '0},
    '{'{awn_pkg::OP_WRITE, 11'd255,  11'd0,    24'h555555}, 1'b0, '0},
    '{'{awn_pkg::OP_WRITE, 11'd2047, 11'd2047, 24'h123456}, 1'b0, '0},
    '{'{awn_pkg::OP_WRITE, 11'd256,  11'd3,    24'h654321}, 1'b0, '0},
    '{'{awn_pkg::OP_WRITE, 11'd3,    11'd256,  24'h654321}, 1'b0, '0},
    '{'{awn_pkg::OP_READ,  11'd0,    11'd0,    24'h000000}, 1'b1,
      '{24'hFFFFFF, awn_pkg::ST_COPIED}},
    '{'{awn_pkg::OP_READ,  11'd255,  11'd255,  24'hFFFFFF}, 1'b1,
      '{24'h000000, awn_pkg::ST_COPIED}},
    '{'{awn_pkg::OP_READ,  11'd0,    11'd255,  24'h000000}, 1'b1,
      '{24'hAAAAAA, awn_pkg::ST_COPIED}},
    '{'{awn_pkg::OP_READ,  11'd255,  11'd0,    24'h000000}, 1'b1,
      '{24'h555555, awn_pkg::ST_COPIED}},
    '{'{awn_pkg::OP_READ,  11'd256,  11'd0,    24'h000000}, 1'b1,
      '{24'h000000, awn_pkg::ST_OUTSIDE_FRAME}},
    '{'{awn_pkg::OP_READ,  11'd0,    11'd256,  24'h000000}, 1'b1,
      '{24'h000000, awn_pkg::ST_OUTSIDE_FRAME}},
    '{'{awn_pkg::OP_READ,  11'd2047, 11'd2047, 24'hFFFFFF}, 1'b1,
      '{24'h000000, awn_pkg::ST_OUTSIDE_FRAME}},
    '{'{awn_pkg::OP_READ,  11'd0,    11'd0,    24'h000000}, 1'b0, '0}
  };

  logic [awn_pkg::COEF_W-1:0] phase_regs [10][8] = '{
    '{16'd8192, 16'd0, 16'd0, 16'd8192, 16'd0, 16'd0, 16'd256, 16'd256},
    '{16'd4096, 16'd4096, 16'd4096, 16'd4096, 16'd0, 16'd0, 16'd256, 16'd256},
    '{16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'd1, 16'd1},
    '{16'd4096, 16'd0, 16'd0, 16'd4096, 16'd0, 16'd0, 16'd0, 16'd0},
    '{16'd4096, 16'd0, 16'd0, 16'd4096, 16'h0035, 16'hFFC3, 16'd511, 16'd300},
    '{16'd3547, 16'hF800, 16'd2048, 16'd3547, 16'h0100, 16'hFF80, 16'd200, 16'd180},
    '{16'd2048, 16'd0, 16'd0, 16'd2048, 16'h0000, 16'h0000, 16'd256, 16'd256},
    '{16'hF000, 16'd0, 16'd0, 16'd4096, 16'd0, 16'd0, 16'd256, 16'd256},
    '{16'd5000, 16'd1200, 16'hFC00, 16'd4500, 16'h8000, 16'h7FFF, 16'd64, 16'd32},
    '{16'd4096, 16'd0, 16'd0, 16'd4096, 16'd0, 16'd0, 16'd256, 16'd256}
  };

  initial begin
    logic [awn_pkg::COEF_W-1:0] rnd_regs [8];
    cycle_count = 0;
    fail_count  = 0;
    quiet       = 1'b0;
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_data     = '0;
    cfg_valid   = 1'b0;
    cfg_index   = '0;
    cfg_data    = '0;
    m_a = 16'sd4096; m_b = '0; m_c = '0; m_d = 16'sd4096;
    m_sx = '0; m_sy = '0; m_w = 9'd256; m_h = 9'd256;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (dir_rows[i]) send_word(dir_rows[i].word, dir_rows[i].fixed, dir_rows[i].want);

    foreach (phase_regs[p]) run_phase(phase_regs[p], N_PHASE);
    for (int p = 0; p < 4; p++) begin
      for (int i = 0; i < 6; i++) rnd_regs[i] = awn_pkg::COEF_W'($urandom);
      // keep coefficients near unity so the output frame is mostly nonempty
      for (int i = 0; i < 4; i++)
        rnd_regs[i] = awn_pkg::COEF_W'($urandom_range(6000)) - 16'd1000;
      rnd_regs[6] = awn_pkg::COEF_W'($urandom_range(256, 1));
      rnd_regs[7] = awn_pkg::COEF_W'($urandom_range(256, 1));
      run_phase(rnd_regs, N_PHASE);
    end

    wait_idle();
    if (fail_count == 0) begin
      $display("** affine_warp_nearest: PASSED **");
    end else begin
      $display("** affine_warp_nearest: FAILED **");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/core/awn_pkg.sv
rtl/core/awn_ram.sv
rtl/core/awn_cfg.sv
rtl/core/awn_front.sv
rtl/core/awn_queue.sv
rtl/core/awn_back.sv
rtl/core/affine_warp_nearest.sv
rtl/core/awn_checker.sv
dv/affine_warp_nearest_test.sv
